/* design/ufs_pkg.sv */
// Shared types, constants and helpers for the union-find set store.
`timescale 1ns / 1ps
`default_nettype none
package ufs_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = ADDR_W + 1;
   localparam int PARENT_W     = ADDR_W + 2;
   localparam int GROUP_W      = ADDR_W + 1;

   localparam logic [2:0] CMD_CLEAR     = 3'd0;
   localparam logic [2:0] CMD_FIND      = 3'd1;
   localparam logic [2:0] CMD_SAME      = 3'd2;
   localparam logic [2:0] CMD_JOIN      = 3'd3;
   localparam logic [2:0] CMD_SIZE      = 3'd4;
   localparam logic [2:0] CMD_GROUP_ID  = 3'd5;
   localparam logic [2:0] CMD_GROUP_ROOT = 3'd6;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ELEMENTS);

   typedef struct packed {
      logic [2:0]        command;
      logic [ADDR_W-1:0] first_element;
      logic [ADDR_W-1:0] second_element;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] found_root;
      logic              answer_flag;
      logic [CNT_W-1:0]  set_size;
      logic [ADDR_W-1:0] group_id;
      logic [CNT_W-1:0]  set_count;
      logic              error;
   } rsp_type;

   // Element count in use: zero counts as one, anything above the store as the store size
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
      logic [CNT_W-1:0] res;
      if (raw == '0) begin
         res = CNT_W'(1);
      end else if (raw > MAX_COUNT) begin
         res = MAX_COUNT;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* design/ufs_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ufs_ram #(
   parameter int WIDTH  = 12,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/union_find_sets.sv */
// Union-find set store: command sequencer around parent and group-id memories.
// A find walks the parent path and then compresses it; same and join run two or three finds,
//   group commands and bad indices need no walk; one request is handled at a time.
// The parent-walk loop on the single read port of the parent memory sets the rate.
// Reset, a clear request and every csr write run a clearing pass over all
//   three memories, during which no request is taken.
`timescale 1ns / 1ps
`default_nettype none
module union_find_sets (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire ufs_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output ufs_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_write_en,
   input  wire logic [ufs_pkg::CNT_W-1:0]    csr_write_data
);

   localparam int AW = ufs_pkg::ADDR_W;
   localparam int CW = ufs_pkg::CNT_W;
   localparam int PW = ufs_pkg::PARENT_W;
   localparam int GW = ufs_pkg::GROUP_W;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_ISSUE = 8'b0000_0100,
      S_WALK  = 8'b0000_1000,
      S_COMP  = 8'b0001_0000,
      S_LINK  = 8'b0010_0000,
      S_GRP   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      PH_A  = 3'b001,
      PH_B  = 3'b010,
      PH_A2 = 3'b100
   } phase_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    sets_ff, sets_in;
   logic [AW-1:0]    next_group_ff, next_group_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic             clr_reply_ff, clr_reply_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ufs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [2:0]       cmd_ff, cmd_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [AW-1:0]    b_ff, b_in;
   logic [AW-1:0]    start_ff, start_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    root_ff, root_in;
   logic [CW-1:0]    rsize_ff, rsize_in;
   logic [AW-1:0]    ra_ff, ra_in;
   logic [CW-1:0]    sa_ff, sa_in;
   logic [AW-1:0]    win_ff, win_in;
   logic [AW-1:0]    lose_ff, lose_in;
   logic [AW-1:0]    res_root_ff, res_root_in;
   logic             res_flag_ff, res_flag_in;
   logic [CW-1:0]    res_size_ff, res_size_in;
   logic [AW-1:0]    res_gid_ff, res_gid_in;
   logic             res_err_ff, res_err_in;

   logic             par_we;
   logic [AW-1:0]    par_waddr, par_raddr;
   logic [PW-1:0]    par_wdata, par_rdata;
   logic             grp_we;
   logic [AW-1:0]    rtg_waddr, gtr_waddr;
   logic [GW-1:0]    rtg_wdata, gtr_wdata, rtg_rdata, gtr_rdata;

   logic [CW-1:0]    n_eff;
   logic             accept;
   logic             bad_a, bad_b;
   logic [PW-1:0]    neg_size;
   logic [CW-1:0]    sum_size;

   assign n_eff    = ufs_pkg::eff_count(count_ff);
   assign accept   = req_valid && req_ready;
   assign bad_a    = {1'b0, req_data.first_element} >= n_eff;
   assign bad_b    = {1'b0, req_data.second_element} >= n_eff;
   assign neg_size = PW'(0) - par_rdata;
   assign sum_size = sa_ff + rsize_ff;

   ufs_ram #(.WIDTH(PW), .ADDR_W(AW)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   ufs_ram #(.WIDTH(GW), .ADDR_W(AW)) u_root_to_group (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (rtg_waddr),
      .wr_data (rtg_wdata),
      .rd_addr (a_in),
      .rd_data (rtg_rdata)
   );

   ufs_ram #(.WIDTH(GW), .ADDR_W(AW)) u_group_to_root (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (gtr_waddr),
      .wr_data (gtr_wdata),
      .rd_addr (a_in),
      .rd_data (gtr_rdata)
   );

   // Sequencer: next state, memory accesses and result gathering
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      sets_in       = sets_ff;
      next_group_in = next_group_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_reply_in  = clr_reply_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      cmd_in        = cmd_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      start_in      = start_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      rsize_in      = rsize_ff;
      ra_in         = ra_ff;
      sa_in         = sa_ff;
      win_in        = win_ff;
      lose_in       = lose_ff;
      res_root_in   = res_root_ff;
      res_flag_in   = res_flag_ff;
      res_size_in   = res_size_ff;
      res_gid_in    = res_gid_ff;
      res_err_in    = res_err_ff;
      par_we        = 1'b0;
      par_waddr     = cur_ff;
      par_wdata     = {2'b00, root_ff};
      par_raddr     = cur_ff;
      grp_we        = 1'b0;
      rtg_waddr     = a_ff;
      rtg_wdata     = {1'b1, next_group_ff};
      gtr_waddr     = next_group_ff;
      gtr_wdata     = {1'b1, a_ff};

      case (state_ff)
         S_CLEAR: begin
            // Sweep every entry back to a singleton with no group id
            par_we     = 1'b1;
            par_waddr  = clr_cnt_ff;
            par_wdata  = '1;
            grp_we     = 1'b1;
            rtg_waddr  = clr_cnt_ff;
            rtg_wdata  = '0;
            gtr_waddr  = clr_cnt_ff;
            gtr_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in     = clr_reply_ff ? S_RESP : S_IDLE;
               clr_reply_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in      = req_data.command;
               a_in        = req_data.first_element;
               b_in        = req_data.second_element;
               start_in    = req_data.first_element;
               cur_in      = req_data.first_element;
               par_raddr   = req_data.first_element;
               phase_in    = PH_A;
               res_root_in = '0;
               res_flag_in = 1'b0;
               res_size_in = '0;
               res_gid_in  = '0;
               res_err_in  = 1'b0;
               case (req_data.command)
                  ufs_pkg::CMD_CLEAR: begin
                     state_in      = S_CLEAR;
                     clr_cnt_in    = '0;
                     clr_reply_in  = 1'b1;
                     sets_in       = n_eff;
                     next_group_in = '0;
                  end
                  ufs_pkg::CMD_FIND, ufs_pkg::CMD_SIZE: begin
                     res_err_in = bad_a;
                     state_in   = bad_a ? S_RESP : S_WALK;
                  end
                  ufs_pkg::CMD_SAME, ufs_pkg::CMD_JOIN: begin
                     res_err_in = bad_a || bad_b;
                     state_in   = (bad_a || bad_b) ? S_RESP : S_WALK;
                  end
                  ufs_pkg::CMD_GROUP_ID, ufs_pkg::CMD_GROUP_ROOT: begin
                     res_err_in = bad_a;
                     state_in   = bad_a ? S_RESP : S_GRP;
                  end
                  default: begin
                     res_err_in = 1'b1;
                     state_in   = S_RESP;
                  end
               endcase
            end
         end
         S_ISSUE: begin
            par_raddr = cur_ff;
            state_in  = S_WALK;
         end
         S_WALK: begin
            // Follow parent links until a negative entry marks the root
            if (par_rdata[PW-1]) begin
               root_in   = cur_ff;
               rsize_in  = neg_size[CW-1:0];
               cur_in    = start_ff;
               par_raddr = start_ff;
               state_in  = S_COMP;
            end else begin
               cur_in    = par_rdata[AW-1:0];
               par_raddr = par_rdata[AW-1:0];
            end
         end
         S_COMP: begin
            if (cur_ff != root_ff) begin
               // Point this element straight at the root and advance
               par_we    = 1'b1;
               par_waddr = cur_ff;
               par_wdata = {2'b00, root_ff};
               cur_in    = par_rdata[AW-1:0];
               par_raddr = par_rdata[AW-1:0];
            end else if (phase_ff == PH_A &&
                         (cmd_ff == ufs_pkg::CMD_SAME || cmd_ff == ufs_pkg::CMD_JOIN)) begin
               // Hold the first root, then walk from the second element
               ra_in     = root_ff;
               sa_in     = rsize_ff;
               phase_in  = PH_B;
               start_in  = b_ff;
               cur_in    = b_ff;
               par_raddr = b_ff;
               state_in  = S_WALK;
            end else if (phase_ff == PH_B) begin
               res_root_in = ra_ff;
               res_size_in = sa_ff;
               res_flag_in = (root_ff == ra_ff);
               state_in    = S_RESP;
               if (cmd_ff == ufs_pkg::CMD_JOIN) begin
                  res_flag_in = 1'b0;
                  if (root_ff != ra_ff) begin
                     // Larger set's root wins; on a tie the first root is kept
                     if (sa_ff < rsize_ff) begin
                        win_in  = root_ff;
                        lose_in = ra_ff;
                        par_waddr = root_ff;
                     end else begin
                        win_in  = ra_ff;
                        lose_in = root_ff;
                        par_waddr = ra_ff;
                     end
                     par_we    = 1'b1;
                     par_wdata = PW'(0) - {1'b0, sum_size};
                     state_in  = S_LINK;
                  end
               end
            end else begin
               res_root_in = root_ff;
               res_size_in = rsize_ff;
               state_in    = S_RESP;
            end
         end
         S_LINK: begin
            // Hang the losing root under the winner, then find the first element again
            par_we      = 1'b1;
            par_waddr   = lose_ff;
            par_wdata   = {2'b00, win_ff};
            res_flag_in = 1'b1;
            if (sets_ff != '0) begin
               sets_in = sets_ff - CW'(1);
            end
            phase_in = PH_A2;
            start_in = a_ff;
            cur_in   = a_ff;
            state_in = S_ISSUE;
         end
         S_GRP: begin
            if (cmd_ff == ufs_pkg::CMD_GROUP_ID) begin
               res_root_in = a_ff;
               if (rtg_rdata[GW-1]) begin
                  res_gid_in = rtg_rdata[AW-1:0];
               end else begin
                  // First request for this element: hand out the next id
                  grp_we        = 1'b1;
                  res_gid_in    = next_group_ff;
                  next_group_in = next_group_ff + AW'(1);
               end
            end else if (gtr_rdata[GW-1]) begin
               res_root_in = gtr_rdata[AW-1:0];
               res_gid_in  = a_ff;
            end else begin
               res_err_in = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found_root  = res_root_ff;
               rsp_data_in.answer_flag = res_flag_ff;
               rsp_data_in.set_size    = res_size_ff;
               rsp_data_in.group_id    = res_gid_ff;
               rsp_data_in.set_count   = sets_ff;
               rsp_data_in.error       = res_err_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write restarts the clearing pass
      if (csr_write_en) begin
         count_in      = csr_write_data;
         sets_in       = ufs_pkg::eff_count(csr_write_data);
         next_group_in = '0;
         clr_cnt_in    = '0;
         state_in      = S_CLEAR;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         phase_ff      <= PH_A;
         count_ff      <= ufs_pkg::MAX_COUNT;
         sets_ff       <= ufs_pkg::MAX_COUNT;
         next_group_ff <= '0;
         clr_cnt_ff    <= '0;
         clr_reply_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         sets_ff       <= sets_in;
         next_group_ff <= next_group_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_reply_ff  <= clr_reply_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff      <= cmd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      start_ff    <= start_in;
      cur_ff      <= cur_in;
      root_ff     <= root_in;
      rsize_ff    <= rsize_in;
      ra_ff       <= ra_in;
      sa_ff       <= sa_in;
      win_ff      <= win_in;
      lose_ff     <= lose_in;
      res_root_ff <= res_root_in;
      res_flag_ff <= res_flag_in;
      res_size_ff <= res_size_in;
      res_gid_ff  <= res_gid_in;
      res_err_ff  <= res_err_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_sets_bounded: assert property (@(posedge clock) disable iff (reset)
      sets_ff <= n_eff)
      else $error("set count above element count");

   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> (win_ff != lose_ff))
      else $error("join links a root to itself");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write_en) |=> (state_ff != S_IDLE))
      else $error("accepted request left no work");

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && !rsp_ready && !csr_write_en) |=>
      (state_ff == S_RESP))
      else $error("result dropped while output full");

endmodule
`default_nettype wire

/* tb/tb_union_find_sets.sv */
// Self-checking testbench for the union-find set store: directed table, then random phases.
`timescale 1ns / 1ps
`default_nettype none
module tb_union_find_sets;

   localparam int AW = ufs_pkg::ADDR_W;
   localparam int CW = ufs_pkg::CNT_W;
   localparam int ME = ufs_pkg::MAX_ELEMENTS;
   localparam logic [2:0] CMD_UNKNOWN = 3'd7;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int CLEAR_WAIT  = 1200;
   localparam int HOLD_CYCLES = 3000;

   typedef enum logic [1:0] {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      ufs_pkg::req_type request;
      bit               typed;
      ufs_pkg::rsp_type result;
      logic [CW-1:0]    csr_value;
   } row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   ufs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   ufs_pkg::rsp_type rsp_data;
   logic             csr_write_en;
   logic [CW-1:0]    csr_write_data;

   // Mirror of the store
   int               parent_or_size_m[ME];
   logic [AW-1:0]    root_group_m[ME];
   bit               root_has_group_m[ME];
   logic [AW-1:0]    group_root_m[ME];
   bit               group_live_m[ME];
   int               next_group_m;
   int               sets_left_m;
   logic [CW-1:0]    count_raw_m;

   ufs_pkg::rsp_type pending_results[$];
   row_type          stimulus_rows[$];
   int               fail_count = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   bit               hold_off_req = 1'b0;

   // Receiver pattern state
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               mode_left = 0;
   int               rx_mode = 0;
   bit               ready_next;

   union_find_sets i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int active_elements();
      if (count_raw_m == '0) return 1;
      if (count_raw_m > ME) return ME;
      return int'(count_raw_m);
   endfunction

   function automatic void clear_sets();
      for (int i = 0; i < ME; i++) begin
         parent_or_size_m[i] = -1;
         root_group_m[i]     = '0;
         root_has_group_m[i] = 1'b0;
         group_root_m[i]     = '0;
         group_live_m[i]     = 1'b0;
      end
      next_group_m = 0;
      sets_left_m  = active_elements();
   endfunction

   // Walk to the root, then point the walked path straight at it
   function automatic int root_of(int u);
      int root;
      int cur;
      int nxt;
      int steps;
      root = u;
      cur = u;
      steps = 0;
      while (parent_or_size_m[root] >= 0 && steps < ME) begin
         root = parent_or_size_m[root] % ME;
         steps++;
      end
      steps = 0;
      while (cur != root && parent_or_size_m[cur] >= 0 && steps < ME) begin
         nxt = parent_or_size_m[cur] % ME;
         parent_or_size_m[cur] = root;
         cur = nxt;
         steps++;
      end
      return root;
   endfunction

   function automatic logic [CW-1:0] size_of(int r);
      int v;
      v = parent_or_size_m[r];
      return v < 0 ? CW'(-v) : '0;
   endfunction

   function automatic ufs_pkg::rsp_type apply_request(ufs_pkg::req_type q);
      ufs_pkg::rsp_type r;
      int n;
      int a;
      int b;
      int ra;
      int rb;
      int t;
      int g;
      r = '0;
      n = active_elements();
      a = int'(q.first_element);
      b = int'(q.second_element);
      case (q.command)
         ufs_pkg::CMD_CLEAR: clear_sets();
         ufs_pkg::CMD_FIND, ufs_pkg::CMD_SIZE: begin
            if (a >= n) begin
               r.error = 1'b1;
            end else begin
               ra = root_of(a);
               r.found_root = AW'(ra);
               r.set_size = size_of(ra);
            end
         end
         ufs_pkg::CMD_SAME: begin
            if (a >= n || b >= n) begin
               r.error = 1'b1;
            end else begin
               ra = root_of(a);
               r.answer_flag = (root_of(b) == ra);
               r.found_root = AW'(ra);
               r.set_size = size_of(ra);
            end
         end
         ufs_pkg::CMD_JOIN: begin
            if (a >= n || b >= n) begin
               r.error = 1'b1;
            end else begin
               ra = root_of(a);
               rb = root_of(b);
               if (ra != rb) begin
                  // keep the larger root, the first on a tie
                  if (size_of(ra) < size_of(rb)) begin
                     t = ra;
                     ra = rb;
                     rb = t;
                  end
                  parent_or_size_m[ra] += parent_or_size_m[rb];
                  parent_or_size_m[rb] = ra;
                  if (sets_left_m > 0) sets_left_m--;
                  r.answer_flag = 1'b1;
               end
               ra = root_of(a);
               r.found_root = AW'(ra);
               r.set_size = size_of(ra);
            end
         end
         ufs_pkg::CMD_GROUP_ID: begin
            if (a >= n) begin
               r.error = 1'b1;
            end else begin
               if (!root_has_group_m[a]) begin
                  g = next_group_m % ME;
                  root_has_group_m[a] = 1'b1;
                  root_group_m[a] = AW'(g);
                  group_root_m[g] = AW'(a);
                  group_live_m[g] = 1'b1;
                  next_group_m++;
               end
               r.found_root = AW'(a);
               r.group_id = root_group_m[a];
            end
         end
         ufs_pkg::CMD_GROUP_ROOT: begin
            if (a >= n || !group_live_m[a]) begin
               r.error = 1'b1;
            end else begin
               r.found_root = group_root_m[a];
               r.group_id = AW'(a);
            end
         end
         default: r.error = 1'b1;
      endcase
      r.set_count = CW'(sets_left_m);
      return r;
   endfunction

   function automatic ufs_pkg::rsp_type mk_result(int root, bit flag, int size, int gid,
                                                  int count, bit err);
      ufs_pkg::rsp_type r;
      r.found_root  = AW'(root);
      r.answer_flag = flag;
      r.set_size    = CW'(size);
      r.group_id    = AW'(gid);
      r.set_count   = CW'(count);
      r.error       = err;
      return r;
   endfunction

   function automatic ufs_pkg::req_type mk_request(logic [2:0] cmd, int a, int b);
      ufs_pkg::req_type q;
      q.command = cmd;
      q.first_element = AW'(a);
      q.second_element = AW'(b);
      return q;
   endfunction

   // Append one row to the stimulus table
   function automatic void append_row(row_type row);
      stimulus_rows = {stimulus_rows, row};
   endfunction

   // Queue one expected result behind the others
   function automatic void queue_result(ufs_pkg::rsp_type r);
      pending_results = {pending_results, r};
   endfunction

   function automatic void add_typed(logic [2:0] cmd, int a, int b, ufs_pkg::rsp_type r);
      row_type row;
      row.kind = ROW_REQUEST;
      row.request = mk_request(cmd, a, b);
      row.typed = 1'b1;
      row.result = r;
      row.csr_value = '0;
      append_row(row);
   endfunction

   function automatic void add_predicted(logic [2:0] cmd, int a, int b);
      row_type row;
      row.kind = ROW_REQUEST;
      row.request = mk_request(cmd, a, b);
      row.typed = 1'b0;
      row.result = '0;
      row.csr_value = '0;
      append_row(row);
   endfunction

   function automatic void add_csr(int value);
      row_type row;
      row.kind = ROW_CSR;
      row.request = '0;
      row.typed = 1'b0;
      row.result = '0;
      row.csr_value = CW'(value);
      append_row(row);
   endfunction

   // Random request, mostly in range and aimed at live group ids
   function automatic ufs_pkg::req_type random_request();
      int n;
      int pick;
      int a;
      int b;
      logic [2:0] cmd;
      n = active_elements();
      pick = $urandom_range(0, 999);
      if (pick < 3) cmd = ufs_pkg::CMD_CLEAR;
      else if (pick < 15) cmd = CMD_UNKNOWN;
      else if (pick < 315) cmd = ufs_pkg::CMD_JOIN;
      else if (pick < 465) cmd = ufs_pkg::CMD_FIND;
      else if (pick < 615) cmd = ufs_pkg::CMD_SAME;
      else if (pick < 715) cmd = ufs_pkg::CMD_SIZE;
      else if (pick < 865) cmd = ufs_pkg::CMD_GROUP_ID;
      else cmd = ufs_pkg::CMD_GROUP_ROOT;
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
      if (cmd == ufs_pkg::CMD_GROUP_ROOT && next_group_m > 0 && $urandom_range(0, 99) < 85)
         a = $urandom_range(0, next_group_m - 1);
      return mk_request(cmd, a, b);
   endfunction

   // Offer one request in bursts with gaps; return at the accepting edge
   task automatic send_request(ufs_pkg::req_type q, bit typed,
                               ufs_pkg::rsp_type typed_result);
      int gap;
      ufs_pkg::rsp_type r;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      r = apply_request(q);
      queue_result(typed ? typed_result : r);
   endtask

   // Drop valid, drain, let any clearing pass finish, then write the count
   task automatic write_count(logic [CW-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (CLEAR_WAIT) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      count_raw_m = value;
      clear_sets();
      burst_left = 0;
   endtask

   // Receiver: stall pattern, one long hold-off, and result checks
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, rsp_data);
            fail_count++;
         end else begin
            automatic ufs_pkg::rsp_type e = pending_results.pop_front();
            if (rsp_data.found_root !== e.found_root) begin
               $display("%0t: found_root expected %0d actual %0d", $realtime,
                        e.found_root, rsp_data.found_root);
               fail_count++;
            end
            if (rsp_data.answer_flag !== e.answer_flag) begin
               $display("%0t: answer_flag expected %0d actual %0d", $realtime,
                        e.answer_flag, rsp_data.answer_flag);
               fail_count++;
            end
            if (rsp_data.set_size !== e.set_size) begin
               $display("%0t: set_size expected %0d actual %0d", $realtime,
                        e.set_size, rsp_data.set_size);
               fail_count++;
            end
            if (rsp_data.group_id !== e.group_id) begin
               $display("%0t: group_id expected %0d actual %0d", $realtime,
                        e.group_id, rsp_data.group_id);
               fail_count++;
            end
            if (rsp_data.set_count !== e.set_count) begin
               $display("%0t: set_count expected %0d actual %0d", $realtime,
                        e.set_count, rsp_data.set_count);
               fail_count++;
            end
            if (rsp_data.error !== e.error) begin
               $display("%0t: error expected %0d actual %0d", $realtime,
                        e.error, rsp_data.error);
               fail_count++;
            end
         end
      end
      if (hold_off_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else begin
         case (rx_mode)
            0: ready_next = 1'b1;
            1: ready_next = $urandom_range(0, 1);
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = ($urandom_range(0, 15) != 0);
         endcase
      end
      rsp_ready <= ready_next;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_union_find_sets NOT OK");
         $finish;
      end
   end

   initial begin
      int phase_counts[9];
      int phase_items[9];
      row_type row;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      reset          = 1'b1;
      count_raw_m    = CW'(ME);
      clear_sets();

      // Directed rows at the reset count of 1024
      add_typed(ufs_pkg::CMD_FIND, 0, 0, mk_result(0, 0, 1, 0, 1024, 0));
      add_typed(ufs_pkg::CMD_FIND, 1023, 1023, mk_result(1023, 0, 1, 0, 1024, 0));
      add_typed(ufs_pkg::CMD_SIZE, 5, 0, mk_result(5, 0, 1, 0, 1024, 0));
      add_typed(ufs_pkg::CMD_SAME, 0, 1023, mk_result(0, 0, 1, 0, 1024, 0));
      add_typed(ufs_pkg::CMD_JOIN, 0, 1023, mk_result(0, 1, 2, 0, 1023, 0));
      add_typed(ufs_pkg::CMD_JOIN, 1023, 0, mk_result(0, 0, 2, 0, 1023, 0));
      add_typed(ufs_pkg::CMD_SAME, 1023, 0, mk_result(0, 1, 2, 0, 1023, 0));
      add_typed(ufs_pkg::CMD_GROUP_ID, 1023, 0, mk_result(1023, 0, 0, 0, 1023, 0));
      add_typed(ufs_pkg::CMD_GROUP_ID, 0, 0, mk_result(0, 0, 0, 1, 1023, 0));
      add_typed(ufs_pkg::CMD_GROUP_ID, 1023, 0, mk_result(1023, 0, 0, 0, 1023, 0));
      add_typed(ufs_pkg::CMD_GROUP_ROOT, 1, 0, mk_result(0, 0, 0, 1, 1023, 0));
      add_typed(ufs_pkg::CMD_GROUP_ROOT, 2, 0, mk_result(0, 0, 0, 0, 1023, 1));
      add_typed(CMD_UNKNOWN, 1023, 1023, mk_result(0, 0, 0, 0, 1023, 1));
      add_predicted(ufs_pkg::CMD_JOIN, 2, 3);
      add_predicted(ufs_pkg::CMD_JOIN, 4, 2);
      add_predicted(ufs_pkg::CMD_JOIN, 2, 0);
      add_predicted(ufs_pkg::CMD_FIND, 3, 0);
      add_predicted(ufs_pkg::CMD_SIZE, 4, 0);
      add_typed(ufs_pkg::CMD_CLEAR, 0, 0, mk_result(0, 0, 0, 0, 1024, 0));
      add_typed(ufs_pkg::CMD_GROUP_ROOT, 0, 0, mk_result(0, 0, 0, 0, 1024, 1));
      // Two elements in use: bad indices, then a join and a find
      add_csr(2);
      add_typed(ufs_pkg::CMD_FIND, 2, 0, mk_result(0, 0, 0, 0, 2, 1));
      add_typed(ufs_pkg::CMD_JOIN, 0, 1023, mk_result(0, 0, 0, 0, 2, 1));
      add_typed(ufs_pkg::CMD_JOIN, 0, 1, mk_result(0, 1, 2, 0, 1, 0));
      add_typed(ufs_pkg::CMD_FIND, 1, 0, mk_result(0, 0, 2, 0, 1, 0));
      // A count of zero counts as one
      add_csr(0);
      add_typed(ufs_pkg::CMD_FIND, 1, 0, mk_result(0, 0, 0, 0, 1, 1));
      add_typed(ufs_pkg::CMD_FIND, 0, 0, mk_result(0, 0, 1, 0, 1, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (stimulus_rows[i]) begin
         row = stimulus_rows[i];
         if (row.kind == ROW_CSR) write_count(row.csr_value);
         else send_request(row.request, row.typed, row.result);
      end

      // Random phases over several counts, the extremes among them
      phase_counts = '{2047, 1, 2, 3, 16, 64, 1023, 100, 1024};
      phase_items  = '{300, 40, 80, 80, 300, 300, 300, 150, 400};
      for (int p = 0; p < 9; p++) begin
         write_count(CW'(phase_counts[p]));
         if (p == 4) hold_off_req = 1'b1;
         for (int k = 0; k < phase_items[p]; k++)
            send_request(random_request(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_union_find_sets OK");
      end else begin
         $display("tb_union_find_sets NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
